### rtl/sbl_pkg.sv
// ---------------------------------------------------------------------------
// sbl_pkg
// Shared types, codes and sizes of the sorted bounded list.
// ---------------------------------------------------------------------------
package sbl_pkg;

  localparam int CAPACITY = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 3;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // depth of the command and result queues
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;
  typedef logic [2:0]        count_out_t;

  // operation codes on the input port
  localparam logic [2:0] OP_INSERT       = 3'd0;
  localparam logic [2:0] OP_REMOVE_AT    = 3'd1;
  localparam logic [2:0] OP_REMOVE_BELOW = 3'd2;
  localparam logic [2:0] OP_REMOVE_KIND  = 3'd3;
  localparam logic [2:0] OP_READ_AT      = 3'd4;

  // decoded command kinds handed to the back end
  localparam logic [2:0] CMD_NOP          = 3'd0;
  localparam logic [2:0] CMD_INSERT       = 3'd1;
  localparam logic [2:0] CMD_REMOVE_AT    = 3'd2;
  localparam logic [2:0] CMD_REMOVE_BELOW = 3'd3;
  localparam logic [2:0] CMD_REMOVE_KIND  = 3'd4;
  localparam logic [2:0] CMD_READ_AT      = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [31:0] area;
    logic [1:0]  kind;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic [2:0]       cmd;
    entry_t           item;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    entry_t     item;
    count_out_t count;
  } result_t;

  function automatic qptr_t next_ptr(input qptr_t ptr);
    if (ptr == qptr_t'(QDEPTH - 1)) begin
      return '0;
    end
    return ptr + qptr_t'(1);
  endfunction

endpackage

### rtl/sorted_bounded_list.sv
// ---------------------------------------------------------------------------
// sorted_bounded_list
// Bounded list of up to five entries, kept in order of area, largest first.
//
// Input channel: a word is taken when push is high and full is low. It
// carries operation, area_key, kind_tag, handle and position.
// Result channel: while empty is low the oldest result word sits on status,
// out_area, out_kind, out_handle and entry_count; pop with empty low takes it.
// Every input word yields exactly one result word, in order.
// A word that is taken is decoded into a two-word command queue; once the
// back end takes it, it is carried out against the entry cells and its
// result word is queued for the result ports, oldest first.
// Throughput: one word per cycle while results are popped; each command,
// including compaction of the cells, is carried out whole as the back end takes it.
// When pop is held low the two-word result queue fills, the back end stops
// taking commands, the command queue fills and full rises.
// Reset (rst, synchronous) empties both queues and the list; entry contents
// are not cleared and are never read until written.
// ---------------------------------------------------------------------------
module sorted_bounded_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] area_key,
  input  logic [1:0]  kind_tag,
  input  logic [15:0] handle,
  input  logic [2:0]  position,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] out_area,
  output logic [1:0]  out_kind,
  output logic [15:0] out_handle,
  output logic [2:0]  entry_count
);
  import sbl_pkg::*;

  logic    cmd_valid;
  logic    cmd_take;
  cmd_t    cmd;
  result_t result;

  sbl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .area_key  (area_key),
    .kind_tag  (kind_tag),
    .handle    (handle),
    .position  (position),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sbl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign status      = result.status;
  assign out_area    = result.item.area;
  assign out_kind    = result.item.kind;
  assign out_handle  = result.item.handle;
  assign entry_count = result.count;

endmodule

### rtl/sbl_front.sv
// ---------------------------------------------------------------------------
// sbl_front
// Accepts words, decodes the operation and holds them in a short queue
// until the back end takes them.
// ---------------------------------------------------------------------------
module sbl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            operation,
  input  logic [31:0]           area_key,
  input  logic [1:0]            kind_tag,
  input  logic [15:0]           handle,
  input  logic [2:0]            position,
  output logic                  cmd_valid,
  output sbl_pkg::cmd_t         cmd,
  input  logic                  cmd_take
);
  import sbl_pkg::*;

  cmd_t  queue [QDEPTH];
  qptr_t wr_ptr;
  qptr_t rd_ptr;
  qcnt_t count;
  cmd_t  decoded;
  logic  do_push;
  logic  do_pop;

  always_comb begin
    decoded.item.area   = area_key;
    decoded.item.kind   = kind_tag;
    decoded.item.handle = handle;
    decoded.position    = position;
    unique case (operation)
      OP_INSERT:       decoded.cmd = CMD_INSERT;
      OP_REMOVE_AT:    decoded.cmd = CMD_REMOVE_AT;
      OP_REMOVE_BELOW: decoded.cmd = CMD_REMOVE_BELOW;
      OP_REMOVE_KIND:  decoded.cmd = CMD_REMOVE_KIND;
      OP_READ_AT:      decoded.cmd = CMD_READ_AT;
      default:         decoded.cmd = CMD_NOP;
    endcase
  end

  assign full      = (count == qcnt_t'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + qcnt_t'(1);
      end else if (do_pop && !do_push) begin
        count <= count - qcnt_t'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qcnt_t'(QDEPTH))
    else $error("command queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + qcnt_t'(1))
    else $error("command queue lost a word");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - qcnt_t'(1))
    else $error("command queue kept a taken word");

endmodule

### rtl/sbl_back.sv
// ---------------------------------------------------------------------------
// sbl_back
// Holds the entry cells, carries out one command per cycle while the
// result queue has room and queues the result words for the receiver.
// ---------------------------------------------------------------------------
module sbl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  sbl_pkg::cmd_t         cmd,
  output logic                  cmd_take,
  output logic                  empty,
  input  logic                  pop,
  output sbl_pkg::result_t      result
);
  import sbl_pkg::*;

  entry_t  entries      [CAPACITY];
  entry_t  entries_next [CAPACITY];
  entry_t  packed_list  [CAPACITY];
  entry_t  inserted     [CAPACITY];
  cnt_t    rank         [CAPACITY];
  cnt_t    fill;
  cnt_t    fill_next;
  cnt_t    kept;
  cnt_t    at;
  logic    [CAPACITY-1:0] valid;
  logic    [CAPACITY-1:0] drop;
  logic    [CAPACITY-1:0] keep;
  logic    pos_bad;
  entry_t  picked;
  result_t res;
  logic    sorted_ok;

  result_t rqueue [QDEPTH];
  qptr_t   wr_ptr;
  qptr_t   rd_ptr;
  qcnt_t   rcount;
  logic    do_pop;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (cnt_t'(i) < fill);
    end
    pos_bad = (cmp_t'(cmd.position) >= cmp_t'(fill));

    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmp_t'(i) == cmp_t'(cmd.position)) begin
        picked = entries[i];
      end
    end

    // entries to drop for the compacting commands
    for (int i = 0; i < CAPACITY; i++) begin
      case (cmd.cmd)
        CMD_REMOVE_AT:    drop[i] = (cmp_t'(i) == cmp_t'(cmd.position));
        CMD_REMOVE_BELOW: drop[i] = (entries[i].area < cmd.item.area);
        CMD_REMOVE_KIND:  drop[i] = (entries[i].kind == cmd.item.kind);
        default:          drop[i] = 1'b0;
      endcase
      keep[i] = valid[i] && !drop[i];
    end

    // rank of each kept entry = its slot after closing the gaps
    kept = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rank[i] = kept;
      if (keep[i]) begin
        kept = kept + cnt_t'(1);
      end
    end
    for (int j = 0; j < CAPACITY; j++) begin
      packed_list[j] = entries[j];
      for (int i = 0; i < CAPACITY; i++) begin
        if (keep[i] && rank[i] == cnt_t'(j)) begin
          packed_list[j] = entries[i];
        end
      end
    end

    // list is sorted largest first, so the first smaller area is the slot
    at = fill;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid[i] && entries[i].area < cmd.item.area) begin
        at = cnt_t'(i);
      end
    end
    for (int j = 0; j < CAPACITY; j++) begin
      if (cnt_t'(j) < at) begin
        inserted[j] = entries[j];
      end else if (cnt_t'(j) == at) begin
        inserted[j] = cmd.item;
      end else begin
        inserted[j] = entries[(j > 0) ? j - 1 : 0];
      end
    end

    entries_next = entries;
    fill_next    = fill;
    res.status   = ST_OK;
    res.item     = '0;
    unique case (cmd.cmd) inside
      CMD_INSERT: begin
        if (fill == cnt_t'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          entries_next = inserted;
          fill_next    = fill + cnt_t'(1);
        end
      end
      CMD_REMOVE_AT, CMD_READ_AT: begin
        if (pos_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.item = picked;
          if (cmd.cmd == CMD_REMOVE_AT) begin
            entries_next = packed_list;
            fill_next    = kept;
          end
        end
      end
      CMD_REMOVE_BELOW, CMD_REMOVE_KIND: begin
        entries_next = packed_list;
        fill_next    = kept;
      end
      default: ;
    endcase
    res.count = count_out_t'(fill_next);

    sorted_ok = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      if (valid[i] && entries[i-1].area < entries[i].area) begin
        sorted_ok = 1'b0;
      end
    end
  end

  assign cmd_take = cmd_valid && (rcount != qcnt_t'(QDEPTH));
  assign empty    = (rcount == '0);
  assign result   = rqueue[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      entries        <= entries_next;
      rqueue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      rcount <= '0;
    end else begin
      if (cmd_take) begin
        fill   <= fill_next;
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      if (cmd_take && !do_pop) begin
        rcount <= rcount + qcnt_t'(1);
      end else if (do_pop && !cmd_take) begin
        rcount <= rcount - qcnt_t'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cnt_t'(CAPACITY))
    else $error("fill count beyond capacity");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    sorted_ok)
    else $error("stored entries out of order");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.cmd == CMD_INSERT && fill != cnt_t'(CAPACITY))
      |=> fill == $past(fill) + cnt_t'(1))
    else $error("insert did not add an entry");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.cmd == CMD_INSERT && fill == cnt_t'(CAPACITY))
      |=> $stable(fill))
    else $error("rejected insert changed the list");

  a_rqueue_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= qcnt_t'(QDEPTH))
    else $error("result queue count beyond depth");

endmodule
